>>> src/s2d_pkg.sv
package s2d_pkg;

  localparam int VALUE_W = 64;
  localparam int DIGIT_W = 4;
  localparam int CYC_W   = $clog2(VALUE_W);

  // Control from the sequencer to the shift-and-add-3 unit
  typedef struct packed {
    logic load;     // take a new value, clear the digit register
    logic dabble;   // one bit step of the conversion
    logic advance;  // move the next digit into the top slot
  } s2d_ctrl_t;

endpackage

>>> src/s2d_dabble.sv
module s2d_dabble #(
  parameter int MAX_DIGITS = 19
) (
  input  logic                                clk,
  input  s2d_pkg::s2d_ctrl_t                  ctrl,
  input  logic signed [s2d_pkg::VALUE_W-1:0] value,
  output logic        [s2d_pkg::DIGIT_W-1:0] top_digit,
  output logic                                ovf
);
  import s2d_pkg::*;

  localparam int BCD_W = MAX_DIGITS * DIGIT_W;

  logic [VALUE_W-1:0] mag;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   adj;

  // Add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
      bcd <= '0;
      ovf <= 1'b0;
    end else if (ctrl.dabble) begin
      mag <= mag << 1;
      bcd <= {adj[BCD_W-2:0], mag[VALUE_W-1]};
      // a carry out of the top digit means upper digits are dropped
      ovf <= ovf | adj[BCD_W-1];
    end else if (ctrl.advance) begin
      bcd <= bcd << DIGIT_W;
    end
  end

  assign top_digit = bcd[BCD_W-1 -: DIGIT_W];

endmodule

>>> src/signed_binary_to_decimal_digits.sv
// Flow: a word is taken while idle, converted by shift-and-add-3 over all
//   VALUE_W bits, then MAX_DIGITS slots are walked, leading zero slots skipped.
// Overlap: a new word is taken only after the last slot of the one before;
//   the single shift-and-add-3 unit sets this; a full output stalls the walk.
// Reset: rst (synchronous, active high) clears the sequencer and the output
//   valid; the digit datapath holds no reset and is loaded with each word.
module signed_binary_to_decimal_digits #(
  parameter int MAX_DIGITS = 19
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                value_valid,
  output logic                                value_ready,
  input  logic signed [s2d_pkg::VALUE_W-1:0] value,
  output logic                                digit_valid,
  input  logic                                digit_ready,
  output logic                                negative,
  output logic        [s2d_pkg::DIGIT_W-1:0] digit,
  output logic                                last_digit
);
  import s2d_pkg::*;

  localparam int CNT_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic [CYC_W-1:0]   cnt;
  logic [CNT_W-1:0]   idx;
  logic               started;
  logic               neg;

  s2d_ctrl_t          ctrl;
  logic [DIGIT_W-1:0] top_digit;
  logic               ovf;

  logic               accept;
  logic               slot_free;
  logic               show;
  logic               load_out;

  // Only an idle sequencer takes a new word; a finished digit may still
  // wait in the output register meanwhile.
  assign value_ready = (state == ST_IDLE);
  assign accept      = value_valid && value_ready;

  // The output register is free when empty or being drained this cycle
  assign slot_free = !digit_valid || digit_ready;

  // A slot is shown once a non-zero digit has appeared, when upper digits
  // were dropped (all kept slots count), or on the units slot.
  assign show     = started || ovf || (top_digit != '0) || (idx == '0);
  assign load_out = (state == ST_EMIT) && show && slot_free;

  always_comb begin
    ctrl.load    = accept;
    ctrl.dabble  = (state == ST_CONV);
    ctrl.advance = (state == ST_EMIT) && (!show || slot_free);
  end

  s2d_dabble #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dabble (
    .clk       (clk),
    .ctrl      (ctrl),
    .value     (value),
    .top_digit (top_digit),
    .ovf       (ovf)
  );

  // Sequencer: convert over all VALUE_W bits, then walk the digit slots top down
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      idx     <= '0;
      started <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state   <= ST_CONV;
            cnt     <= '0;
            started <= 1'b0;
          end
        end
        ST_CONV: begin
          cnt <= cnt + CYC_W'(1);
          if (cnt == CYC_W'(VALUE_W - 1)) begin
            state <= ST_EMIT;
            idx   <= CNT_W'(MAX_DIGITS - 1);
          end
        end
        ST_EMIT: begin
          if (ctrl.advance) begin
            if (show) begin
              started <= 1'b1;
            end
            if (idx == '0) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx - CNT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the sign of the word for all its digits
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value[VALUE_W-1];
    end
  end

  // Output register: valid under reset, payload loaded with each digit
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (load_out) begin
      digit_valid <= 1'b1;
    end else if (digit_ready) begin
      digit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      negative   <= neg;
      digit      <= top_digit;
      last_digit <= (idx == '0);
    end
  end

`ifndef ASSERT_OFF
  // An accepted word always starts a fresh conversion
  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CONV) && (cnt == '0))
    else $error("accepted word did not start a conversion");

  // The units digit closes the run and frees the sequencer
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (load_out && (idx == '0)) |=> (state == ST_IDLE) && digit_valid && last_digit)
    else $error("final digit did not end the run");

  // Every digit shown is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> (digit <= DIGIT_W'(9)))
    else $error("digit out of decimal range");

  // Digits are only loaded while walking the slots
  a_load_in_emit: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (state == ST_EMIT) && !value_ready)
    else $error("digit loaded outside the emit phase");
`endif

endmodule

>>> tb/sv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_DIGITS = 19;
  localparam int          VW         = s2d_pkg::VALUE_W;
  localparam logic [63:0] TEN_18     = 64'd1000000000000000000;
  localparam logic [63:0] TWO_63     = 64'h8000_0000_0000_0000;

  // One expected digit word, field for field as the output ports carry it
  typedef struct {
    logic                         negative;
    logic [s2d_pkg::DIGIT_W-1:0] digit;
    logic                         last_digit;
  } digit_word_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 value_valid = 1'b0;
  logic                                 value_ready;
  logic signed [VW-1:0]                 value = '0;
  logic                                 digit_valid;
  logic                                 digit_ready = 1'b0;
  logic                                 negative;
  logic        [s2d_pkg::DIGIT_W-1:0]   digit;
  logic                                 last_digit;

  digit_word_t pending_digits[$];
  int          mismatch_count = 0;
  // Random idling on both sides; cleared for the closing stretch
  bit          idle_on = 1'b1;
  int          stall_left = 0;

  signed_binary_to_decimal_digits #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .value_valid(value_valid),
    .value_ready(value_ready),
    .value      (value),
    .digit_valid(digit_valid),
    .digit_ready(digit_ready),
    .negative   (negative),
    .digit      (digit),
    .last_digit (last_digit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Work out the digit words one input word must produce: exact unsigned
  // magnitude, least significant digit first into a buffer, then keep only
  // the lowest MAX_DIGITS digits and queue them most significant first.
  function automatic void split_into_digits(input logic signed [VW-1:0] word);
    logic [VW-1:0] mag;
    logic [3:0]    slots[20];
    int            n;
    digit_word_t   rec;
    mag = word[VW-1] ? (~word + 64'd1) : word;
    n = 0;
    do begin
      slots[n] = 4'(mag % 64'd10);
      mag      = mag / 64'd10;
      n++;
    end while (mag != 0 && n < 20);
    if (n > MAX_DIGITS) n = MAX_DIGITS;
    for (int k = 0; k < n; k++) begin
      rec.negative   = word[VW-1];
      rec.digit      = slots[n-1-k];
      rec.last_digit = (k == n - 1);
      pending_digits.push_back(rec);
    end
  endfunction

  // Build a magnitude with exactly ndig decimal digits. Bias the lower
  // digits now and then towards all nines or mostly zeros.
  function automatic logic [63:0] magnitude_of_width(input int ndig);
    logic [63:0] m;
    int          mode;
    int          d;
    if (ndig >= 19) begin
      m = {$urandom, $urandom} & ~TWO_63;
      return TEN_18 + m % (TWO_63 - TEN_18);
    end
    mode = $urandom_range(0, 3);
    m    = 64'($urandom_range(1, 9));
    for (int i = 1; i < ndig; i++) begin
      case (mode)
        1: begin
          d = 9;
        end
        2: begin
          d = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
        end
        default: begin
          d = $urandom_range(0, 9);
        end
      endcase
      m = m * 64'd10 + 64'(d);
    end
    return m;
  endfunction

  // Offer one word, hold it until it is taken, then queue its digits.
  task automatic send_word(input logic signed [VW-1:0] word);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      value_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    value_valid <= 1'b1;
    value       <= word;
    @(posedge clk);
    while (!value_ready) @(posedge clk);
    split_into_digits(word);
  endtask

  // Receiver side: drop ready in random bursts while idling is on
  always @(negedge clk) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 3) == 0)
      stall_left = $urandom_range(1, 10);
    if (idle_on && stall_left > 0) begin
      stall_left--;
      digit_ready <= 1'b0;
    end else begin
      stall_left = 0;
      digit_ready <= 1'b1;
    end
  end

  // Compare every digit word taken against the oldest expectation
  always @(posedge clk) begin : check_digits
    digit_word_t want;
    if (!rst && digit_valid && digit_ready) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected digit word: negative %0d digit %0d last_digit %0d",
               negative, digit, last_digit);
        mismatch_count++;
      end else begin
        want = pending_digits.pop_front();
        if (negative !== want.negative) begin
          $error("negative: expected %0d, got %0d", want.negative, negative);
          mismatch_count++;
        end
        if (digit !== want.digit) begin
          $error("digit: expected %0d, got %0d", want.digit, digit);
          mismatch_count++;
        end
        if (last_digit !== want.last_digit) begin
          $error("last_digit: expected %0d, got %0d", want.last_digit, last_digit);
          mismatch_count++;
        end
      end
    end
  end

  // Zero, single digits, powers of ten either side, the extremes of the
  // range including the most negative value, and alternating bit patterns.
  task automatic test_corner_values();
    logic signed [VW-1:0] corners[$];
    corners = '{64'sd0, 64'sd1, -64'sd1, 64'sd9, -64'sd9, 64'sd10, -64'sd10,
                64'sd99, 64'sd100, -64'sd1000000000,
                64'sd999999999999999999, 64'sd1000000000000000000,
                -64'sd1000000000000000000,
                64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000,
                64'sh8000_0000_0000_0001, -64'sh7FFF_FFFF_FFFF_FFFF,
                64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA,
                64'sd12345678901234567, -64'sd987654321,
                64'sh0000_0001_0000_0000, -64'sh0000_0001_0000_0000,
                64'sd9999999999};
    foreach (corners[i]) send_word(corners[i]);
  endtask

  // Random digit counts from 1 to 19, either sign
  task automatic test_random_widths(input int count);
    logic [63:0] m;
    int          ndig;
    bit          neg;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) idle_on = ~idle_on;
      ndig = $urandom_range(1, 19);
      neg  = $urandom_range(0, 1);
      m    = magnitude_of_width(ndig);
      if (neg && ndig == 19 && $urandom_range(0, 9) == 0) m = TWO_63;
      send_word(neg ? (~m + 64'd1) : m);
    end
  endtask

  // Raw 64-bit patterns so that each bit of the word is seen at both levels
  task automatic test_full_range(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) idle_on = ~idle_on;
      send_word({$urandom, $urandom});
    end
  endtask

  // Closing stretch: no idling on either side, words back to back
  task automatic test_streaming(input int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0)
        send_word({$urandom, $urandom});
      else
        send_word(magnitude_of_width($urandom_range(1, 19)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_values();
    idle_on = 1'b1;
    test_random_widths(140);
    idle_on = 1'b1;
    test_full_range(90);
    test_streaming(60);

    @(negedge clk);
    value_valid <= 1'b0;

    // Drain, then watch a little longer for stray digit words
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (MAX_DIGITS + 80) @(posedge clk);

    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/s2d_pkg.sv
src/s2d_dabble.sv
src/signed_binary_to_decimal_digits.sv
tb/sv/tb.sv
